@@ sv/psn_pkg.sv @@
// shared types, constants and saturation helpers for the periodic stencil sweep core
// no dependencies; imported by psn_mul, psn_div, the top level and the testbench
package psn_pkg;

    // lattice storage
    localparam int CELLS = 8192;
    localparam int IDX_W = $clog2(CELLS);
    localparam int LEN_W = IDX_W + 1;

    // fixed point format
    localparam int Q_W    = 48;
    localparam int FRAC   = 32;
    localparam int WIDE_W = Q_W + 8;
    localparam int MAG_W  = 64;

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [MAG_W-1:0]         t_mag;

    localparam t_q   QMAX     = {1'b0, {(Q_W-1){1'b1}}};
    localparam t_q   QMIN     = {1'b1, {(Q_W-1){1'b0}}};
    localparam t_mag MAG_HALF = MAG_W'(1) << (Q_W - 1);

    // commands on the input tuser
    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_U_SWEEP = 3'd1,
        CMD_COUPLE  = 3'd2,
        CMD_C_SWEEP = 3'd3,
        CMD_READ    = 3'd4,
        CMD_TOTALS  = 3'd5
    } t_cmd;

    // result kinds on the output tuser
    typedef enum logic [1:0] {
        KIND_REPORT  = 2'd0,
        KIND_READOUT = 2'd1,
        KIND_TOTALS  = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DIFF     = 3'd0,
        REG_DRIFT    = 3'd1,
        REG_DECAY    = 3'd2,
        REG_GAIN     = 3'd3,
        REG_STEP     = 3'd4,
        REG_INTERVAL = 3'd5,
        REG_CELLS    = 3'd6
    } t_reg;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PRE_A,
        S_PRE_B,
        S_PRE_C,
        S_FETCH,
        S_LOAD,
        S_MUL,
        S_QUOT,
        S_DIV,
        S_WB,
        S_SUM_RD,
        S_SUM_ADD,
        S_CPL_RD,
        S_CPL_WR,
        S_CELL_RD,
        S_CELL_MUL,
        S_TOT_RD,
        S_TOT_MUL,
        S_SCALE,
        S_EMIT
    } t_state;

    // clamp a wide exact sum into the 48-bit range
    function automatic t_q sat_q(input t_wide x);
        t_q res;
        if (x > t_wide'(QMAX)) begin
            res = QMAX;
        end else if (x < t_wide'(QMIN)) begin
            res = QMIN;
        end else begin
            res = x[Q_W-1:0];
        end
        return res;
    endfunction

    // signed result from a sign, an overflow mark and a magnitude
    function automatic t_q sat_mag(input logic neg, input logic ovf, input t_mag m);
        t_q res;
        if (neg) begin
            if (ovf || m >= MAG_HALF) begin
                res = QMIN;
            end else begin
                res = -t_q'(m[Q_W-1:0]);
            end
        end else begin
            if (ovf || m > t_mag'(QMAX)) begin
                res = QMAX;
            end else begin
                res = t_q'(m[Q_W-1:0]);
            end
        end
        return res;
    endfunction

    // magnitude of a signed value
    function automatic logic [Q_W-1:0] mag_q(input t_q x);
        logic [Q_W-1:0] res;
        res = x[Q_W-1] ? Q_W'(-x) : Q_W'(x);
        return res;
    endfunction

endpackage

@@ sv/periodic_stencil_newton_sweep_core.sv @@
// periodic stencil Newton sweep core: u/c profiles, sweeps, couple, readout and totals
// depends on psn_pkg, psn_mul, psn_div
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser cmd, tdata cell/u/c
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser kind, tdata step/cell/values/fault
//  cfg       in   i_cfg_we                     i_cfg_idx, i_cfg_wdata
//
// load writes a cell while idle; a read returns u, c and their product for one cell;
// couple adds twice u to the shift store; a sweep updates each cell with four (u)
//   or three (c) products on the shared multiplier and a divide, after a setup pass
// totals, and a due report after a u sweep, sum over the lattice and scale by the step
// after reset a clearing pass zeroes the shift store; no input meanwhile
// input ready only while idle; one result may wait in the output register
module periodic_stencil_newton_sweep_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  psn_pkg::t_q   i_cfg_wdata,
    // commands
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [2:0]    s_axis_tuser,   // cmd
    input  logic [111:0]  s_axis_tdata,   // cell_index, u_load, c_load, zero pad
    // results
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [1:0]    m_axis_tuser,   // kind
    output logic [191:0]  m_axis_tdata    // step, cell, first, second, third, fault, pad
);
    import psn_pkg::*;

    // configuration registers
    t_q                r_diff;
    t_q                r_drift;
    t_q                r_decay;
    t_q                r_gain;
    logic [Q_W-2:0]    r_h;
    logic [15:0]       r_interval;
    logic [LEN_W-1:0]  r_cells;

    // lattice memories
    t_q                u_mem [CELLS];
    t_q                c_mem [CELLS];
    t_q                s_mem [CELLS];
    t_q                r_u_rd;
    t_q                r_c_rd;
    t_q                r_s_rd;

    // sequencer
    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    logic              r_is_c;
    logic [IDX_W-1:0]  r_idx;
    logic [LEN_W-1:0]  r_i;
    logic [2:0]        r_term;
    logic              r_mwait;
    logic [4:0]        r_bitc;
    logic [31:0]       r_tsh;
    logic [15:0]       r_rem;
    logic              r_report;

    // sweep datapath
    t_q                r_m;
    t_q                r_p;
    t_wide             r_base;
    t_q                r_d;
    t_q                r_xl;
    t_q                r_xc;
    t_q                r_xr;
    t_q                r_x0;
    t_wide             r_f;
    t_q                r_new;
    t_q                r_acc1;
    t_q                r_acc2;
    t_q                r_v1;
    t_q                r_v2;
    t_q                r_v3;

    // status and output
    logic [31:0]       r_count;
    logic [31:0]       r_tstep;
    logic              r_fault;
    logic              r_ovalid;
    t_kind             r_okind;
    logic [31:0]       r_ostep;
    logic [IDX_W-1:0]  r_ocell;
    t_q                r_o1;
    t_q                r_o2;
    t_q                r_o3;
    logic              r_ofault;

    logic              w_accept;
    t_cmd              w_cmd;
    logic [IDX_W-1:0]  w_in_idx;
    t_q                w_in_u;
    t_q                w_in_c;
    logic [LEN_W-1:0]  w_n;
    logic [LEN_W-1:0]  w_capped;
    logic [LEN_W-1:0]  w_last;
    logic [LEN_W-1:0]  w_i_next;
    logic [IDX_W-1:0]  w_rd_addr;
    t_q                w_x_rd;
    logic [15:0]       w_iv;
    logic [16:0]       w_mtrial;
    logic              w_mge;
    logic [15:0]       w_rem_next;
    logic              w_last_term;
    logic              w_emit_ok;
    t_q                w_q;
    t_q                w_f_sat;
    t_q                w_shift_new;
    logic              w_u_we;
    logic              w_c_we;
    logic              w_s_we;
    logic [IDX_W-1:0]  w_x_wa;
    t_q                w_u_wd;
    t_q                w_c_wd;
    t_q                w_s_wd;

    logic              mul_start;
    t_q                mul_a;
    t_q                mul_b;
    logic              mul_done;
    t_q                mul_res;
    logic              div_start;
    logic              div_done;
    t_q                div_res;

    // input fields
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_cmd    = t_cmd'(s_axis_tuser);
    assign w_in_idx = s_axis_tdata[12:0];
    assign w_in_u   = s_axis_tdata[60:13];
    assign w_in_c   = s_axis_tdata[108:61];

    // lattice length: capped, even, at least four
    assign w_capped = (r_cells > LEN_W'(CELLS)) ? LEN_W'(CELLS) : r_cells;
    assign w_n      = ({w_capped[LEN_W-1:1], 1'b0} < LEN_W'(4)) ? LEN_W'(4)
                    : {w_capped[LEN_W-1:1], 1'b0};
    assign w_last   = w_n - LEN_W'(1);
    assign w_i_next = r_i + LEN_W'(1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff     <= 48'sd429496729600;
            r_drift    <= '0;
            r_decay    <= 48'sd8589935;
            r_gain     <= 48'sd4294967296;
            r_h        <= 47'd429496730;
            r_interval <= 16'd1000;
            r_cells    <= LEN_W'(CELLS);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_DIFF:     r_diff     <= i_cfg_wdata;
                REG_DRIFT:    r_drift    <= i_cfg_wdata;
                REG_DECAY:    r_decay    <= i_cfg_wdata;
                REG_GAIN:     r_gain     <= i_cfg_wdata;
                REG_STEP:     r_h        <= i_cfg_wdata[Q_W-2:0];
                REG_INTERVAL: r_interval <= i_cfg_wdata[15:0];
                REG_CELLS:    r_cells    <= i_cfg_wdata[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // shared arithmetic units
    psn_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    psn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (w_f_sat),
        .i_b     (w_q),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // read address for the profile memories
    always_comb begin
        case (r_state)
            S_PRE_A:   w_rd_addr = w_last[IDX_W-1:0];
            S_PRE_B:   w_rd_addr = '0;
            S_FETCH:   w_rd_addr = w_i_next[IDX_W-1:0];
            S_CELL_RD, S_CELL_MUL: w_rd_addr = r_idx;
            default:   w_rd_addr = r_i[IDX_W-1:0];
        endcase
    end

    assign w_x_rd = r_is_c ? r_c_rd : r_u_rd;

    // memory writes: loads while idle, sweep write-back, clearing and coupling
    assign w_shift_new = sat_q(t_wide'(r_s_rd) + (t_wide'(r_u_rd) <<< 1));
    assign w_x_wa  = (r_state == S_WB) ? r_i[IDX_W-1:0] : w_in_idx;
    assign w_u_we  = (w_accept && w_cmd == CMD_LOAD) || (r_state == S_WB && !r_is_c);
    assign w_c_we  = (w_accept && w_cmd == CMD_LOAD) || (r_state == S_WB && r_is_c);
    assign w_u_wd  = (r_state == S_WB) ? r_new : w_in_u;
    assign w_c_wd  = (r_state == S_WB) ? r_new : w_in_c;
    assign w_s_we  = (r_state == S_CLEAR) || (r_state == S_CPL_WR);
    assign w_s_wd  = (r_state == S_CLEAR) ? '0 : w_shift_new;

    always_ff @(posedge i_clk) begin
        if (w_u_we) begin
            u_mem[w_x_wa] <= w_u_wd;
        end
        r_u_rd <= u_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_c_we) begin
            c_mem[w_x_wa] <= w_c_wd;
        end
        r_c_rd <= c_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            s_mem[r_i[IDX_W-1:0]] <= w_s_wd;
        end
        r_s_rd <= s_mem[r_i[IDX_W-1:0]];
    end

    // report test: remainder of the sweep index by the interval, one bit a cycle
    assign w_iv       = (r_interval == '0) ? 16'd1 : r_interval;
    assign w_mtrial   = {r_rem, r_tsh[31]};
    assign w_mge      = (w_mtrial >= {1'b0, w_iv});
    assign w_rem_next = w_mge ? 16'(w_mtrial - {1'b0, w_iv}) : w_mtrial[15:0];

    // Newton divisor and the saturated residual
    assign w_q     = r_is_c ? r_d : sat_q(t_wide'(r_d) - (t_wide'(r_xc) <<< 2));
    assign w_f_sat = sat_q(r_f);

    assign w_last_term = r_is_c ? (r_term == 3'd2) : (r_term == 3'd3);
    assign w_emit_ok   = !r_ovalid || m_axis_tready;

    // multiplier operands
    always_comb begin
        mul_a = r_u_rd;
        mul_b = r_c_rd;
        case (r_state)
            S_MUL: begin
                case (r_term)
                    3'd0:    begin mul_a = r_m;  mul_b = r_xl; end
                    3'd1:    begin mul_a = r_d;  mul_b = r_xc; end
                    3'd2:    begin mul_a = r_p;  mul_b = r_xr; end
                    default: begin mul_a = r_xc; mul_b = r_xc; end
                endcase
            end
            S_SCALE: begin
                mul_a = (r_term == 3'd0) ? r_acc1 : r_acc2;
                mul_b = t_q'({1'b0, r_h});
            end
            default: ;
        endcase
    end

    assign mul_start = !r_mwait && (r_state == S_MUL || r_state == S_TOT_MUL
                       || r_state == S_CELL_MUL || r_state == S_SCALE);
    assign div_start = (r_state == S_QUOT) && (w_q != '0);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_i == LEN_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (w_cmd)
                        CMD_U_SWEEP: n_state = S_MOD;
                        CMD_C_SWEEP: n_state = S_PRE_A;
                        CMD_COUPLE:  n_state = S_CPL_RD;
                        CMD_READ:    n_state = S_CELL_RD;
                        CMD_TOTALS:  n_state = S_TOT_RD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_MOD:      if (r_bitc == 5'd31) n_state = S_PRE_A;
            S_PRE_A:    n_state = S_PRE_B;
            S_PRE_B:    n_state = S_PRE_C;
            S_PRE_C:    n_state = S_FETCH;
            S_FETCH:    n_state = S_LOAD;
            S_LOAD:     n_state = S_MUL;
            S_MUL:      if (mul_done && w_last_term) n_state = S_QUOT;
            S_QUOT:     n_state = (w_q == '0) ? S_WB : S_DIV;
            S_DIV:      if (div_done) n_state = S_WB;
            S_WB: begin
                if (r_i != w_last) begin
                    n_state = S_FETCH;
                end else if (!r_is_c && r_report) begin
                    n_state = S_SUM_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUM_RD:   n_state = S_SUM_ADD;
            S_SUM_ADD:  n_state = (r_i == w_last) ? S_SCALE : S_SUM_RD;
            S_CPL_RD:   n_state = S_CPL_WR;
            S_CPL_WR:   n_state = (r_i == w_last) ? S_IDLE : S_CPL_RD;
            S_CELL_RD:  n_state = S_CELL_MUL;
            S_CELL_MUL: if (mul_done) n_state = S_EMIT;
            S_TOT_RD:   n_state = S_TOT_MUL;
            S_TOT_MUL: begin
                if (mul_done) begin
                    n_state = (r_i == w_last) ? S_SCALE : S_TOT_RD;
                end
            end
            S_SCALE: begin
                if (mul_done && (r_cmd != CMD_TOTALS || r_term != 3'd0)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT:     if (w_emit_ok) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // sequencer control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_mwait  <= 1'b0;
            r_count  <= '0;
            r_fault  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (mul_start) begin
                r_mwait <= 1'b1;
            end else if (mul_done) begin
                r_mwait <= 1'b0;
            end
            // cell counter
            case (r_state)
                S_CLEAR:  r_i <= w_i_next;
                S_IDLE:   r_i <= '0;
                S_PRE_A:  r_i <= '0;
                S_WB:     r_i <= (r_i == w_last) ? '0 : w_i_next;
                S_SUM_ADD, S_CPL_WR: r_i <= w_i_next;
                S_TOT_MUL: if (mul_done) r_i <= w_i_next;
                default:  ;
            endcase
            // divide fault and sweep count
            if (r_state == S_QUOT && w_q == '0) begin
                r_fault <= 1'b1;
            end
            if (r_state == S_WB && r_i == w_last && !r_is_c) begin
                r_count <= r_count + 32'd1;
            end
            // output register
            if (r_state == S_EMIT && w_emit_ok) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd   <= w_cmd;
                r_is_c  <= (w_cmd == CMD_C_SWEEP);
                r_idx   <= w_in_idx;
                r_tsh   <= r_count;
                r_tstep <= r_count;
                r_rem   <= '0;
                r_bitc  <= '0;
                r_acc1  <= '0;
                r_acc2  <= '0;
                r_v2    <= '0;
                r_v3    <= '0;
                r_term  <= '0;
            end
            S_MOD: begin
                r_rem    <= w_rem_next;
                r_tsh    <= r_tsh << 1;
                r_bitc   <= r_bitc + 5'd1;
                r_report <= (w_rem_next == '0);
            end
            S_PRE_A: begin
                // sweep coefficients, stencil mirrored for c
                r_m    <= sat_q(r_is_c ? t_wide'(r_diff) - t_wide'(r_drift)
                                       : t_wide'(r_diff) + t_wide'(r_drift));
                r_p    <= sat_q(r_is_c ? t_wide'(r_diff) + t_wide'(r_drift)
                                       : t_wide'(r_diff) - t_wide'(r_drift));
                r_base <= -(t_wide'(r_diff) <<< 1) - t_wide'(r_decay);
            end
            S_PRE_B: r_xl <= w_x_rd;
            S_PRE_C: begin
                r_xc <= w_x_rd;
                r_x0 <= w_x_rd;
            end
            S_LOAD: begin
                // right neighbor wraps to the saved old first cell
                r_xr   <= (w_i_next == w_n) ? r_x0 : w_x_rd;
                r_d    <= sat_q(r_base
                        + ((r_i == {1'b0, w_n[LEN_W-1:1]}) ? t_wide'(r_gain) : '0)
                        - (r_is_c ? t_wide'(r_s_rd) : '0));
                r_f    <= '0;
                r_term <= '0;
            end
            S_MUL: begin
                if (mul_done) begin
                    r_f    <= (r_term == 3'd3) ? r_f - (t_wide'(mul_res) <<< 1)
                                               : r_f + t_wide'(mul_res);
                    r_term <= r_term + 3'd1;
                end
            end
            S_QUOT: r_new <= r_xc;
            S_DIV: begin
                if (div_done) begin
                    r_new <= sat_q(t_wide'(r_xc) - t_wide'(div_res));
                end
            end
            S_WB: begin
                r_xl   <= r_xc;
                r_xc   <= r_xr;
                r_term <= '0;
            end
            S_SUM_ADD: r_acc1 <= sat_q(t_wide'(r_acc1) + t_wide'(r_u_rd));
            S_CELL_MUL: begin
                r_v1 <= r_u_rd;
                r_v2 <= r_c_rd;
                if (mul_done) begin
                    r_v3 <= mul_res;
                end
            end
            S_TOT_MUL: begin
                if (mul_done) begin
                    r_acc1 <= sat_q(t_wide'(r_acc1) + t_wide'(r_c_rd));
                    r_acc2 <= sat_q(t_wide'(r_acc2) + t_wide'(mul_res));
                end
            end
            S_SCALE: begin
                if (mul_done) begin
                    if (r_term == 3'd0) begin
                        r_v1 <= mul_res;
                    end else begin
                        r_v2 <= mul_res;
                    end
                    r_term <= r_term + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // output payload, loaded when the result moves into the output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_emit_ok) begin
            r_o1     <= r_v1;
            r_o2     <= r_v2;
            r_o3     <= r_v3;
            r_ofault <= r_fault;
            case (r_cmd)
                CMD_U_SWEEP: begin
                    r_okind <= KIND_REPORT;
                    r_ostep <= r_tstep;
                    r_ocell <= '0;
                end
                CMD_READ: begin
                    r_okind <= KIND_READOUT;
                    r_ostep <= '0;
                    r_ocell <= r_idx;
                end
                default: begin
                    r_okind <= KIND_TOTALS;
                    r_ostep <= '0;
                    r_ocell <= '0;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {2'b00, r_ofault, r_o3, r_o2, r_o1, r_ocell, r_ostep};

    // checks on the sequencer
    a_idle_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_mwait)
        else $error("multiplier still busy while idle");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("divide fault flag cleared");

    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |-> r_i < w_n)
        else $error("sweep write-back beyond lattice length");

    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_mwait)
        else $error("multiplier result without a request");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider result outside the divide step");

endmodule

@@ sv/psn_mul.sv @@
// multi-cycle fixed point multiplier: four half-width partial products, round, saturate
// depends on psn_pkg
module psn_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  psn_pkg::t_q   i_a,
    input  psn_pkg::t_q   i_b,
    output logic          o_done,
    output psn_pkg::t_q   o_res
);
    import psn_pkg::*;

    localparam int H_W = Q_W / 2;
    localparam int P_W = 2 * Q_W;

    logic             r_busy;
    logic [2:0]       r_k;
    logic             r_neg;
    logic [Q_W-1:0]   r_ma;
    logic [Q_W-1:0]   r_mb;
    logic [Q_W-1:0]   r_pp;
    logic [1:0]       r_psh;
    logic             r_pv;
    logic [P_W-1:0]   r_acc;
    logic             r_done;
    t_q               r_res;

    logic [H_W-1:0]   w_ah;
    logic [H_W-1:0]   w_bh;
    logic [P_W-1:0]   w_pp_sh;
    t_mag             w_round;

    // pick the halves for the current partial product
    assign w_ah = r_k[1] ? r_ma[Q_W-1:H_W] : r_ma[H_W-1:0];
    assign w_bh = r_k[0] ? r_mb[Q_W-1:H_W] : r_mb[H_W-1:0];

    // align the registered partial product
    always_comb begin
        case (r_psh)
            2'd0:    w_pp_sh = P_W'(r_pp);
            2'd1:    w_pp_sh = P_W'(r_pp) << H_W;
            2'd2:    w_pp_sh = P_W'(r_pp) << (2 * H_W);
            default: w_pp_sh = '0;
        endcase
    end

    // drop the fraction, round half away from zero on the magnitude
    assign w_round = MAG_W'(r_acc[P_W-1:FRAC]) + MAG_W'(r_acc[FRAC-1]);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_pv   <= 1'b0;
            end else if (r_busy) begin
                r_pv <= (r_k < 3'd4);
                r_k  <= r_k + 3'd1;
                if (r_k == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_neg <= i_a[Q_W-1] ^ i_b[Q_W-1];
            r_ma  <= mag_q(i_a);
            r_mb  <= mag_q(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp  <= w_ah * w_bh;
            r_psh <= 2'(r_k[1]) + 2'(r_k[0]);
            if (r_pv) begin
                r_acc <= r_acc + w_pp_sh;
            end
            if (r_k == 3'd5) begin
                r_res <= sat_mag(r_neg, 1'b0, w_round);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ sv/psn_div.sv @@
// restoring fixed point divider, one quotient bit a cycle, round and saturate
// depends on psn_pkg; the divisor must be nonzero
module psn_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  psn_pkg::t_q   i_a,
    input  psn_pkg::t_q   i_b,
    output logic          o_done,
    output psn_pkg::t_q   o_res
);
    import psn_pkg::*;

    localparam int DV_W  = Q_W + FRAC;
    localparam int CNT_W = $clog2(DV_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [Q_W-1:0]    r_mb;
    logic [DV_W-1:0]   r_dvd;
    logic [Q_W-1:0]    r_rem;
    logic [Q_W:0]      r_q;
    logic              r_ovf;
    t_q                r_res;

    logic [Q_W:0]      w_trial;
    logic              w_ge;
    logic              w_up;
    logic [Q_W+1:0]    w_qr;

    // one step of the long division
    assign w_trial = {r_rem, r_dvd[DV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_mb});
    // final rounding on twice the remainder
    assign w_up    = !r_ovf && ({r_rem, 1'b0} >= {1'b0, r_mb});
    assign w_qr    = {1'b0, r_q} + (Q_W+2)'(w_up);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DV_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_neg <= i_a[Q_W-1] ^ i_b[Q_W-1];
            r_mb  <= mag_q(i_b);
            r_dvd <= {mag_q(i_a), {FRAC{1'b0}}};
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt < CNT_W'(DV_W)) begin
                r_dvd <= r_dvd << 1;
                r_rem <= w_ge ? Q_W'(w_trial - {1'b0, r_mb}) : Q_W'(w_trial);
                if (r_q[Q_W]) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_q <= {r_q[Q_W-1:0], w_ge};
                end
            end else begin
                r_res <= sat_mag(r_neg, r_ovf, MAG_W'(w_qr));
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ verif/periodic_stencil_newton_sweep_core_tb.sv @@
// self-checking testbench for periodic_stencil_newton_sweep_core
// depends on psn_pkg and the core; predicts results with an in-bench fixed point model
`timescale 1ns / 1ps

module periodic_stencil_newton_sweep_core_tb;
    import psn_pkg::*;

    localparam longint QHI = 64'sd140737488355327;
    localparam longint QLO = -QHI - 1;
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam int WATCHDOG = 400000;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] step;
        logic [12:0] echo;
        logic [47:0] first;
        logic [47:0] second;
        logic [47:0] third;
        logic        fault;
    } t_result;

    typedef struct {
        logic [2:0]  cmd;
        logic [12:0] idx;
        logic [47:0] u;
        logic [47:0] c;
        bit          typed;
        t_result     res;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_idx = '0;
    t_q            i_cfg_wdata = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [2:0]    s_axis_tuser = '0;
    logic [111:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b1;
    logic [1:0]    m_axis_tuser;
    logic [191:0]  m_axis_tdata;

    periodic_stencil_newton_sweep_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),   // cmd
        .s_axis_tdata  (s_axis_tdata),   // cell_index, u_load, c_load, zero pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),   // kind
        .m_axis_tdata  (m_axis_tdata)    // step, cell, first, second, third, fault, pad
    );

    always #4 i_clk = ~i_clk;

    // lattice model state and configuration
    longint      u_mem [CELLS];
    longint      c_mem [CELLS];
    longint      shift_mem [CELLS];
    longint      nxt_mem [CELLS];
    bit          loaded [CELLS];
    longint      diff_k, drift_k, decay_k, gain_k, step_h;
    int unsigned interval_k, cells_k;
    logic [31:0] sweep_count;
    bit          fault_seen;

    t_result     pending_results[$];
    t_row        directed_rows[$];
    int          fail_count = 0;
    bit          steady = 1'b0;
    logic [2:0]  last_cmd = CMD_LOAD;

    // saturating fixed point helpers
    function automatic longint sat48(longint x);
        return x > QHI ? QHI : (x < QLO ? QLO : x);
    endfunction

    function automatic longint signed_mag(bit neg, logic [127:0] m);
        longint res;
        if (neg) begin
            res = (m >= (128'(1) << 47)) ? QLO : -longint'(m[63:0]);
        end else begin
            res = (m > 128'(QHI)) ? QHI : longint'(m[63:0]);
        end
        return res;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] ma, mb, pr;
        ma = 128'(a < 0 ? -a : a);
        mb = 128'(b < 0 ? -b : b);
        pr = (ma * mb + (128'(1) << (FRAC - 1))) >> FRAC;
        return signed_mag((a < 0) != (b < 0), pr);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic [127:0] ma, mb, qt, rm;
        ma = 128'(a < 0 ? -a : a) << FRAC;
        mb = 128'(b < 0 ? -b : b);
        qt = ma / mb;
        rm = ma % mb;
        if (2 * rm >= mb) qt = qt + 1;
        return signed_mag((a < 0) != (b < 0), qt);
    endfunction

    function automatic int lattice_cells();
        int n;
        n = (cells_k > CELLS) ? CELLS : int'(cells_k);
        n = n & ~1;
        return (n < 4) ? 4 : n;
    endfunction

    function automatic longint sext48(logic [47:0] v);
        return longint'($signed(v));
    endfunction

    // advance the lattice model by one command; returns 1 when a result is due
    function automatic bit lattice_step_cmd(logic [2:0] cmd, logic [12:0] idx,
                                            logic [47:0] uv, logic [47:0] cv,
                                            output t_result res);
        int n, ctr, il, ir;
        longint base, m, p, d, f, q, acc, acc2, uu;
        int unsigned iv;
        logic [31:0] t;
        bit due;
        n = lattice_cells();
        ctr = n / 2;
        base = -2 * diff_k - decay_k;
        due = 1'b0;
        res = '{default: '0};
        case (cmd)
            CMD_LOAD: begin
                u_mem[idx] = sext48(uv);
                c_mem[idx] = sext48(cv);
            end
            CMD_U_SWEEP: begin
                m = sat48(diff_k + drift_k);
                p = sat48(diff_k - drift_k);
                for (int i = 0; i < n; i++) begin
                    il = (i == 0) ? n - 1 : i - 1;
                    ir = (i + 1 == n) ? 0 : i + 1;
                    uu = u_mem[i];
                    d = sat48(base + ((i == ctr) ? gain_k : 0));
                    f = sat48(fx_mul(m, u_mem[il]) + fx_mul(d, uu) + fx_mul(p, u_mem[ir])
                              - 2 * fx_mul(uu, uu));
                    q = sat48(d - 4 * uu);
                    if (q == 0) begin
                        fault_seen = 1'b1;
                        nxt_mem[i] = uu;
                    end else begin
                        nxt_mem[i] = sat48(uu - fx_div(f, q));
                    end
                end
                for (int i = 0; i < n; i++) u_mem[i] = nxt_mem[i];
                t = sweep_count;
                sweep_count = sweep_count + 32'd1;
                iv = (interval_k == 0) ? 1 : interval_k;
                if (t % iv == 0) begin
                    acc = 0;
                    for (int i = 0; i < n; i++) acc = sat48(acc + u_mem[i]);
                    res.kind = KIND_REPORT;
                    res.step = t;
                    res.first = 48'(fx_mul(acc, step_h));
                    due = 1'b1;
                end
            end
            CMD_COUPLE: begin
                for (int i = 0; i < n; i++) shift_mem[i] = sat48(shift_mem[i] + 2 * u_mem[i]);
            end
            CMD_C_SWEEP: begin
                m = sat48(diff_k - drift_k);
                p = sat48(diff_k + drift_k);
                for (int i = 0; i < n; i++) begin
                    il = (i == 0) ? n - 1 : i - 1;
                    ir = (i + 1 == n) ? 0 : i + 1;
                    d = sat48(base + ((i == ctr) ? gain_k : 0) - shift_mem[i]);
                    f = sat48(fx_mul(m, c_mem[il]) + fx_mul(d, c_mem[i]) + fx_mul(p, c_mem[ir]));
                    if (d == 0) begin
                        fault_seen = 1'b1;
                        nxt_mem[i] = c_mem[i];
                    end else begin
                        nxt_mem[i] = sat48(c_mem[i] - fx_div(f, d));
                    end
                end
                for (int i = 0; i < n; i++) c_mem[i] = nxt_mem[i];
            end
            CMD_READ: begin
                res.kind = KIND_READOUT;
                res.echo = idx;
                res.first = 48'(u_mem[idx]);
                res.second = 48'(c_mem[idx]);
                res.third = 48'(fx_mul(u_mem[idx], c_mem[idx]));
                due = 1'b1;
            end
            CMD_TOTALS: begin
                acc = 0;
                acc2 = 0;
                for (int i = 0; i < n; i++) begin
                    acc = sat48(acc + c_mem[i]);
                    acc2 = sat48(acc2 + fx_mul(u_mem[i], c_mem[i]));
                end
                res.kind = KIND_TOTALS;
                res.first = 48'(fx_mul(acc, step_h));
                res.second = 48'(fx_mul(acc2, step_h));
                due = 1'b1;
            end
            default: ;
        endcase
        res.fault = fault_seen;
        return due;
    endfunction

    // register write, bus held until cfg_release
    task automatic cfg_write(t_reg r, longint raw);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= r;
        i_cfg_wdata <= raw[47:0];
        case (r)
            REG_DIFF:     diff_k = sext48(raw[47:0]);
            REG_DRIFT:    drift_k = sext48(raw[47:0]);
            REG_DECAY:    decay_k = sext48(raw[47:0]);
            REG_GAIN:     gain_k = sext48(raw[47:0]);
            REG_STEP:     step_h = raw & 64'h7FFF_FFFF_FFFF;
            REG_INTERVAL: interval_k = 32'(raw[15:0]);
            REG_CELLS:    cells_k = 32'(raw[13:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic cfg_release();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one command transfer with a random gap ahead of it, none in the steady stretch
    task automatic send_cmd(logic [2:0] cmd, logic [12:0] idx, logic [47:0] uv,
                            logic [47:0] cv, bit typed, t_result typed_res);
        int gap;
        t_result res;
        bit due;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {3'b000, cv, uv, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        due = lattice_step_cmd(cmd, idx, uv, cv, res);
        if (typed) pending_results.push_back(typed_res);
        else if (due) pending_results.push_back(res);
        if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
        last_cmd = cmd;
    endtask

    task automatic send_plain(logic [2:0] cmd, logic [12:0] idx, logic [47:0] uv,
                              logic [47:0] cv);
        send_cmd(cmd, idx, uv, cv, 1'b0, '{default: '0});
    endtask

    // drain results, then let the last silent command finish
    task automatic settle();
        int quiet;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        case (last_cmd)
            CMD_U_SWEEP, CMD_C_SWEEP: quiet = 130 * lattice_cells() + 400;
            CMD_COUPLE:               quiet = 4 * lattice_cells() + 100;
            default:                  quiet = 100;
        endcase
        repeat (quiet) @(posedge i_clk);
    endtask

    function automatic logic [47:0] modest_val();
        return 48'((longint'($urandom) << 3) - (longint'(1) << 34));
    endfunction

    function automatic logic [47:0] wide_val();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic longint coeff_val(bit full);
        int pick;
        pick = $urandom_range(0, 5);
        if (!full) return longint'($urandom_range(0, 32'h3FFF_FFFF)) << 2;
        case (pick)
            0: return QHI;
            1: return QLO;
            default: return sext48(wide_val());
        endcase
    endfunction

    // random phase: fill the lattice unless wide, then mixed commands
    task automatic random_phase(int items, bit full, bit wide, bit zero_u);
        int n, sel, done, pick_cell;
        logic [47:0] uv;
        n = lattice_cells();
        if (!wide) begin
            for (int i = 0; i < n; i++) begin
                uv = zero_u ? 48'd0 : (full ? wide_val() : modest_val());
                send_plain(CMD_LOAD, 13'(i), uv, full ? wide_val() : modest_val());
            end
        end
        done = 0;
        while (done < items) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                send_plain(CMD_LOAD, 13'($urandom_range(0, CELLS - 1)), wide_val(), wide_val());
            end else if (sel < 30 || (wide && sel < 70)) begin
                do pick_cell = $urandom_range(0, CELLS - 1); while (!loaded[pick_cell]);
                send_plain(CMD_READ, 13'(pick_cell), wide_val(), wide_val());
            end else if (wide) begin
                pick_cell = $urandom_range(0, CELLS - 1);
                send_plain(CMD_LOAD, 13'(pick_cell), full ? wide_val() : modest_val(),
                           modest_val());
            end else if (sel < 46) begin
                send_plain(CMD_U_SWEEP, 13'($urandom), wide_val(), wide_val());
            end else if (sel < 54) begin
                send_plain(CMD_COUPLE, 13'($urandom), wide_val(), wide_val());
            end else if (sel < 68) begin
                send_plain(CMD_C_SWEEP, 13'($urandom), wide_val(), wide_val());
            end else if (sel < 78) begin
                send_plain(CMD_TOTALS, 13'($urandom), wide_val(), wide_val());
            end else if (sel < 83) begin
                send_plain(($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B,
                           13'($urandom), wide_val(), wide_val());
                done = done - 1;
            end else begin
                pick_cell = $urandom_range(0, n - 1);
                send_plain(CMD_LOAD, 13'(pick_cell), zero_u ? 48'd0 : modest_val(),
                           modest_val());
            end
            done = done + 1;
        end
        settle();
    endtask

    task automatic add_row(logic [2:0] cmd, logic [12:0] idx, logic [47:0] uv,
                           logic [47:0] cv);
        directed_rows.push_back('{cmd, idx, uv, cv, 1'b0, '{default: '0}});
    endtask

    // result check against the oldest expectation
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_result exp_r;
        int w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d data=%h", $time,
                         m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tuser !== exp_r.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[31:0] !== exp_r.step) begin
                    $display("%0t: step expected %0d actual %0d", $time, exp_r.step,
                             m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[44:32] !== exp_r.echo) begin
                    $display("%0t: cell expected %0d actual %0d", $time, exp_r.echo,
                             m_axis_tdata[44:32]);
                    fail_count++;
                end
                if (m_axis_tdata[92:45] !== exp_r.first) begin
                    $display("%0t: first expected %h actual %h", $time, exp_r.first,
                             m_axis_tdata[92:45]);
                    fail_count++;
                end
                if (m_axis_tdata[140:93] !== exp_r.second) begin
                    $display("%0t: second expected %h actual %h", $time, exp_r.second,
                             m_axis_tdata[140:93]);
                    fail_count++;
                end
                if (m_axis_tdata[188:141] !== exp_r.third) begin
                    $display("%0t: third expected %h actual %h", $time, exp_r.third,
                             m_axis_tdata[188:141]);
                    fail_count++;
                end
                if (m_axis_tdata[189] !== exp_r.fault) begin
                    $display("%0t: fault expected %0d actual %0d", $time, exp_r.fault,
                             m_axis_tdata[189]);
                    fail_count++;
                end
            end
            // randomly stall the result side after a transfer, never in the steady stretch
            w = steady ? 0 : $urandom_range(0, 3);
            if (w == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left <= w;
            end
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("[periodic_stencil_newton_sweep_core] ERROR");
            $finish;
        end
    end

    initial begin
        t_result typed_r;
        t_row row;
        diff_k = 64'sd429496729600;
        drift_k = 0;
        decay_k = 8589935;
        gain_k = 64'sd4294967296;
        step_h = 429496730;
        interval_k = 1000;
        cells_k = 8192;
        sweep_count = '0;
        fault_seen = 1'b0;
        for (int i = 0; i < CELLS; i++) begin
            u_mem[i] = 0;
            c_mem[i] = 0;
            shift_mem[i] = 0;
            loaded[i] = 1'b0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (8400) @(posedge i_clk);

        // directed: small odd length rounds down to four cells
        cfg_write(REG_CELLS, 5);
        cfg_write(REG_DIFF, 64'sd4294967296);
        cfg_write(REG_DRIFT, 64'sd1073741824);
        cfg_write(REG_DECAY, 64'sd42949673);
        cfg_write(REG_GAIN, 64'sd2147483648);
        cfg_write(REG_STEP, 64'sd429496730);
        cfg_write(REG_INTERVAL, 1);
        cfg_release();

        add_row(CMD_LOAD, 0, 48'h0000_4000_0000, 48'h0001_0000_0000);
        add_row(CMD_LOAD, 1, 48'hFFFF_E000_0000, 48'h0000_8000_0000);
        add_row(CMD_LOAD, 2, 48'h0000_1999_9999, 48'hFFFF_0000_0000);
        add_row(CMD_LOAD, 3, 48'h0000_0000_0001, 48'h0000_3333_3333);
        add_row(CMD_LOAD, 5, 48'd0, 48'd0);
        add_row(CMD_LOAD, 8191, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        // extremes read back, product saturates low
        typed_r = '{KIND_READOUT, 32'd0, 13'd8191, 48'h7FFF_FFFF_FFFF,
                    48'h8000_0000_0000, 48'h8000_0000_0000, 1'b0};
        directed_rows.push_back('{CMD_READ, 13'd8191, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                  1'b1, typed_r});
        typed_r = '{KIND_READOUT, 32'd0, 13'd5, 48'd0, 48'd0, 48'd0, 1'b0};
        directed_rows.push_back('{CMD_READ, 13'd5, 48'd0, 48'd0, 1'b1, typed_r});
        add_row(CMD_READ, 1, 48'd0, 48'd0);
        add_row(CMD_U_SWEEP, 0, 48'd0, 48'd0);
        add_row(CMD_COUPLE, 0, 48'd0, 48'd0);
        add_row(CMD_C_SWEEP, 0, 48'd0, 48'd0);
        add_row(CMD_READ, 0, 48'd0, 48'd0);
        add_row(CMD_TOTALS, 0, 48'd0, 48'd0);
        add_row(CMD_SPARE_A, 8191, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_row(CMD_SPARE_B, 0, 48'd0, 48'd0);
        add_row(CMD_U_SWEEP, 0, 48'd0, 48'd0);
        add_row(CMD_READ, 2, 48'd0, 48'd0);
        add_row(CMD_READ, 3, 48'd0, 48'd0);
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_cmd(row.cmd, row.idx, row.u, row.c, row.typed, row.res);
        end
        settle();

        // moderate coefficients, short reporting interval
        cfg_write(REG_CELLS, 2 * $urandom_range(2, 8));
        cfg_write(REG_DIFF, coeff_val(1'b0));
        cfg_write(REG_DRIFT, -coeff_val(1'b0));
        cfg_write(REG_INTERVAL, $urandom_range(1, 3));
        cfg_release();
        random_phase(10, 1'b0, 1'b0, 1'b0);

        // full range coefficients and values, zero interval, largest step
        cfg_write(REG_CELLS, 7);
        cfg_write(REG_DIFF, coeff_val(1'b1));
        cfg_write(REG_DRIFT, coeff_val(1'b1));
        cfg_write(REG_DECAY, QHI);
        cfg_write(REG_GAIN, QLO);
        cfg_write(REG_STEP, QHI);
        cfg_write(REG_INTERVAL, 0);
        cfg_release();
        random_phase(10, 1'b1, 1'b0, 1'b0);

        // zero divisors: flat diagonal and u at zero
        cfg_write(REG_CELLS, 0);
        cfg_write(REG_DIFF, 0);
        cfg_write(REG_DECAY, 0);
        cfg_write(REG_GAIN, 0);
        cfg_write(REG_STEP, 0);
        cfg_write(REG_INTERVAL, 2);
        cfg_release();
        random_phase(10, 1'b0, 1'b0, 1'b1);

        // oversized length and longest interval, loads and reads only
        cfg_write(REG_CELLS, 16383);
        cfg_write(REG_INTERVAL, 65535);
        cfg_write(REG_DRIFT, QLO);
        cfg_release();
        random_phase(10, 1'b1, 1'b1, 1'b0);

        // back-to-back stretch with no idling
        steady = 1'b1;
        cfg_write(REG_CELLS, 16);
        cfg_write(REG_DIFF, 64'sd8589934592);
        cfg_write(REG_DRIFT, 64'sd536870912);
        cfg_write(REG_DECAY, 64'sd429496729);
        cfg_write(REG_GAIN, 64'sd4294967296);
        cfg_write(REG_STEP, 64'sd268435456);
        cfg_write(REG_INTERVAL, 1);
        cfg_release();
        random_phase(12, 1'b0, 1'b0, 1'b0);

        if (fail_count == 0) begin
            $display("[periodic_stencil_newton_sweep_core] OK");
        end else begin
            $display("[periodic_stencil_newton_sweep_core] ERROR");
        end
        $finish;
    end

endmodule
